// ===== design/plcl_pkg.sv =====
// ----------------------------------------------------------------------------
// plcl_pkg
// Shared types and constants of the piecewise-linear colour table generator.
// ----------------------------------------------------------------------------
package plcl_pkg;

  // Default number of control points
  localparam int MaxPointsDef = 16;

  // Field widths
  localparam int PosW   = 17;
  localparam int ColW   = 13;
  localparam int CountW = 5;
  localparam int SizeW  = 13;
  localparam int IdxW   = 12;
  localparam int ByteW  = 8;
  localparam int CfgW   = 13;
  localparam int CountExtW = 9;
  // Position times (table_size - 1)
  localparam int ProdW  = PosW + SizeW;
  // Scaled position: entry index times 65536
  localparam int XW     = IdxW + 16;
  localparam int RemW   = 52;

  // Request modes
  localparam logic ModeWrite = 1'b0;
  localparam logic ModeEntry = 1'b1;

  // Configuration register indexes
  localparam logic CfgPointCount = 1'b0;
  localparam logic CfgTableSize  = 1'b1;

  localparam logic [SizeW-1:0] TableSizeRst = 13'd256;

  typedef struct packed {
    logic            mode;
    logic [3:0]      point_slot;
    logic [PosW-1:0] point_position;
    logic [ColW-1:0] point_red;
    logic [ColW-1:0] point_green;
    logic [ColW-1:0] point_blue;
    logic [ColW-1:0] point_alpha;
    logic [IdxW-1:0] entry_index;
  } plcl_req_t;

  typedef struct packed {
    logic [IdxW-1:0]  entry_out;
    logic [ByteW-1:0] red_byte;
    logic [ByteW-1:0] green_byte;
    logic [ByteW-1:0] blue_byte;
    logic [ByteW-1:0] alpha_byte;
  } plcl_rsp_t;

  // One stored control point; colour has red in the low bits
  typedef struct packed {
    logic [PosW-1:0]   pos;
    logic [4*ColW-1:0] col;
  } plcl_knot_t;

  // Step controls for the channel datapath
  typedef struct packed {
    logic       load_mul;
    logic       load_sum;
    logic       load_prep;
    logic       div_step;
    logic [2:0] div_k;
  } plcl_chan_ctrl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SCAN,
    S_SETUP,
    S_MUL,
    S_SUM,
    S_PREP,
    S_DIV,
    S_STORE,
    S_EMIT
  } plcl_state_e;

endpackage

// ===== design/plcl_if.sv =====
// ----------------------------------------------------------------------------
// plcl_req_if / plcl_rsp_if
// Valid/ready channels carrying requests into and results out of the block.
// ----------------------------------------------------------------------------
interface plcl_req_if;
  import plcl_pkg::*;
  logic      valid;
  logic      ready;
  plcl_req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface plcl_rsp_if;
  import plcl_pkg::*;
  logic      valid;
  logic      ready;
  plcl_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/plcl_knot_mem.sv =====
// ----------------------------------------------------------------------------
// plcl_knot_mem
// Control point store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module plcl_knot_mem #(
  parameter int MAX_POINTS = plcl_pkg::MaxPointsDef,
  parameter int AW         = $clog2(MAX_POINTS)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  plcl_pkg::plcl_knot_t wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output plcl_pkg::plcl_knot_t rdata_o
);
  import plcl_pkg::*;

  plcl_knot_t mem [MAX_POINTS];
  plcl_knot_t rdata_q;

  // Write and read the store
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/plcl_chan_dp.sv =====
// ----------------------------------------------------------------------------
// plcl_chan_dp
// One colour channel: blend two knot values, then clamp and round to a byte
// with an eight-step restoring division.
// ----------------------------------------------------------------------------
module plcl_chan_dp (
  input  logic                         clk_i,
  input  plcl_pkg::plcl_chan_ctrl_t    ctrl_i,
  input  logic [plcl_pkg::ColW-1:0]    a_i,
  input  logic [plcl_pkg::ColW-1:0]    b_i,
  input  logic [plcl_pkg::ProdW-1:0]   den_i,
  input  logic [plcl_pkg::ProdW-1:0]   num_i,
  output logic [plcl_pkg::ByteW-1:0]   byte_o
);
  import plcl_pkg::*;

  localparam int MW = ColW + ProdW;
  localparam int VW = MW + 1;

  logic [ProdW-1:0] diff_w;
  logic [MW-1:0]    m1_q, m2_q;
  logic [VW-1:0]    v_q, full_w;
  logic [RemW-1:0]  rem_q, trial_w, n_w;
  logic             sat_q;
  logic [ByteW-1:0] quo_q;

  assign diff_w  = den_i - num_i;
  assign full_w  = {2'b0, den_i, 12'b0};
  assign n_w     = {v_q, 8'b0} - {8'b0, v_q} + {11'b0, den_i, 11'b0};
  assign trial_w = {10'b0, den_i, 12'b0} << ctrl_i.div_k;

  // Advance the multiply, sum, setup and divide steps
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_mul) begin
      m1_q <= MW'(a_i) * MW'(diff_w);
      m2_q <= MW'(b_i) * MW'(num_i);
    end
    if (ctrl_i.load_sum) begin
      v_q <= {1'b0, m1_q} + {1'b0, m2_q};
    end
    if (ctrl_i.load_prep) begin
      sat_q <= (v_q >= full_w);
      rem_q <= n_w;
      quo_q <= '0;
    end
    if (ctrl_i.div_step) begin
      if (rem_q >= trial_w) begin
        rem_q              <= rem_q - trial_w;
        quo_q[ctrl_i.div_k] <= 1'b1;
      end
    end
  end

  assign byte_o = sat_q ? 8'hFF : quo_q;

endmodule

// ===== design/piecewise_linear_color_lut.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_color_lut
// Piecewise-linear RGBA transfer-function table generator.
// ----------------------------------------------------------------------------
// Usage: requests arrive on req_i. A mode 0 request writes one control point
// and produces no result. A mode 1 request computes one table entry and
// returns it on rsp_o. The control points must be sorted by position and
// written before an entry that uses them is requested. Configuration (point
// count, table size) must be written through cfg_* only while the block is
// idle; the block itself does not enforce this. A write takes effect at once.
// A mode 1 request with no points or a zero table size goes straight to the
// result. Otherwise an entry at or before the first point is clamped to it,
// one at or beyond the last point is clamped to that, and any other entry is
// interpolated after a segment search over the knots. The knot store has a
// single read port, so the search reads one knot a cycle; each of the four
// channels then passes through a shared multiply and eight-step division
// unit. One request is worked at a time; the next is taken once the block
// is back in idle after the result is loaded.
// Reset clears the configuration to no points and a table of 256 entries;
// the knot store is not cleared. The result sits in an output register: a
// new request is accepted while it waits, and the block holds the next
// result until the receiver takes the previous one.
// ----------------------------------------------------------------------------
module piecewise_linear_color_lut #(
  parameter int MAX_POINTS = plcl_pkg::MaxPointsDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_idx_i,
  input  logic [plcl_pkg::CfgW-1:0] cfg_wdata_i,
  plcl_req_if.sink                  req_i,
  plcl_rsp_if.source                rsp_o
);
  import plcl_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam logic [CountExtW-1:0] MaxPtsExt = CountExtW'(MAX_POINTS);

  plcl_state_e state_q, state_d;

  logic [CountW-1:0]    pc_q;
  logic [SizeW-1:0]     ts_q;
  logic [CountExtW-1:0] n_w, hi_q;
  logic [XW-1:0]        x_q;
  logic [SizeW-1:0]     y_q;
  logic [IdxW-1:0]      idx_q;
  logic [PosW-1:0]      pa_q, pb_q;
  logic [4*ColW-1:0]    ca_q, cb_q;
  logic [ProdW-1:0]     den_q, num_q;
  logic [1:0]           chan_q;
  logic [2:0]           div_cnt_q;
  logic [ByteW-1:0]     bytes_q [4];
  logic                 out_valid_q;
  plcl_rsp_t            out_q;

  plcl_knot_t           rd_w, wr_w;
  logic [AW-1:0]        raddr_w, waddr_w;
  logic                 we_w;
  logic [ProdW-1:0]     prod_w, x_ext_w;
  logic                 first_le_w, last_ge_w, scan_go_w;
  logic                 accept_w, out_load_w;
  logic                 slot_ok_w;
  plcl_chan_ctrl_t      ctrl_w;
  logic [ByteW-1:0]     byte_w;

  // Saturate the point count to the store depth
  assign n_w = ({4'b0, pc_q} > MaxPtsExt) ? MaxPtsExt : {4'b0, pc_q};

  assign accept_w = req_i.valid && req_i.ready;
  assign x_ext_w  = {2'b0, x_q};
  assign prod_w   = ProdW'({13'b0, rd_w.pos} * {17'b0, y_q});

  assign first_le_w = (x_ext_w <= prod_w);
  assign last_ge_w  = (x_ext_w >= prod_w);
  assign scan_go_w  = (hi_q < n_w - 9'd1) && (prod_w < x_ext_w);

  assign slot_ok_w = ({5'b0, req_i.data.point_slot} < MaxPtsExt);
  assign waddr_w   = AW'({5'b0, req_i.data.point_slot});
  assign wr_w.pos  = req_i.data.point_position;
  assign wr_w.col  = {req_i.data.point_alpha, req_i.data.point_blue,
                      req_i.data.point_green, req_i.data.point_red};

  plcl_knot_mem #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW)
  ) u_knot_mem (
    .clk_i   (clk_i),
    .we_i    (we_w),
    .waddr_i (waddr_w),
    .wdata_i (wr_w),
    .raddr_i (raddr_w),
    .rdata_o (rd_w)
  );

  plcl_chan_dp u_chan_dp (
    .clk_i  (clk_i),
    .ctrl_i (ctrl_w),
    .a_i    (ca_q[chan_q*ColW +: ColW]),
    .b_i    (cb_q[chan_q*ColW +: ColW]),
    .den_i  (den_q),
    .num_i  (num_q),
    .byte_o (byte_w)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_i.valid && req_i.data.mode == ModeEntry) begin
          state_d = (n_w == '0 || ts_q == '0) ? S_EMIT : S_FIRST;
        end
      end
      S_FIRST: state_d = first_le_w ? S_MUL : S_LAST;
      S_LAST:  state_d = last_ge_w ? S_MUL : S_SCAN;
      S_SCAN: begin
        if (!scan_go_w) begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: state_d = S_MUL;
      S_MUL:   state_d = S_SUM;
      S_SUM:   state_d = S_PREP;
      S_PREP:  state_d = S_DIV;
      S_DIV: begin
        if (div_cnt_q == 3'd0) begin
          state_d = S_STORE;
        end
      end
      S_STORE: state_d = (chan_q == 2'd3) ? S_EMIT : S_MUL;
      S_EMIT: begin
        if (!out_valid_q || rsp_o.ready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Handshake, store access and datapath steps
  always_comb begin
    req_i.ready      = 1'b0;
    we_w             = 1'b0;
    raddr_w          = '0;
    ctrl_w           = '0;
    ctrl_w.div_k     = div_cnt_q;
    out_load_w       = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        we_w        = req_i.valid && req_i.data.mode == ModeWrite && slot_ok_w;
      end
      S_FIRST: raddr_w = AW'(n_w - 9'd1);
      S_LAST:  raddr_w = AW'(9'd1);
      S_SCAN:  raddr_w = AW'(hi_q + 9'd1);
      S_MUL:   ctrl_w.load_mul  = 1'b1;
      S_SUM:   ctrl_w.load_sum  = 1'b1;
      S_PREP:  ctrl_w.load_prep = 1'b1;
      S_DIV:   ctrl_w.div_step  = 1'b1;
      S_EMIT:  out_load_w = !out_valid_q || rsp_o.ready;
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pc_q        <= '0;
      ts_q        <= TableSizeRst;
      out_valid_q <= 1'b0;
      chan_q      <= '0;
      div_cnt_q   <= '0;
      hi_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgPointCount: pc_q <= cfg_wdata_i[CountW-1:0];
          CfgTableSize:  ts_q <= cfg_wdata_i[SizeW-1:0];
          default: ;
        endcase
      end
      if (out_load_w) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (accept_w) begin
        chan_q <= '0;
      end else if (state_q == S_STORE) begin
        chan_q <= chan_q + 2'd1;
      end
      if (state_q == S_PREP) begin
        div_cnt_q <= 3'd7;
      end else if (state_q == S_DIV) begin
        div_cnt_q <= div_cnt_q - 3'd1;
      end
      if (state_q == S_LAST) begin
        hi_q <= 9'd1;
      end else if (state_q == S_SCAN && scan_go_w) begin
        hi_q <= hi_q + 9'd1;
      end
    end
  end

  // Request operands, segment search and channel results
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        idx_q <= req_i.data.entry_index;
        if (ts_q == 13'd1) begin
          x_q <= '0;
          y_q <= 13'd1;
        end else begin
          x_q <= {req_i.data.entry_index, 16'b0};
          y_q <= ts_q - 13'd1;
        end
        bytes_q[0] <= '0;
        bytes_q[1] <= '0;
        bytes_q[2] <= '0;
        bytes_q[3] <= '0;
      end
      S_FIRST: begin
        ca_q  <= rd_w.col;
        cb_q  <= rd_w.col;
        pa_q  <= rd_w.pos;
        den_q <= ProdW'(1);
        num_q <= '0;
      end
      S_LAST: begin
        if (last_ge_w) begin
          ca_q <= rd_w.col;
        end
      end
      S_SCAN: begin
        if (scan_go_w) begin
          ca_q <= rd_w.col;
          pa_q <= rd_w.pos;
        end else begin
          cb_q <= rd_w.col;
          pb_q <= rd_w.pos;
        end
      end
      S_SETUP: begin
        if (pb_q > pa_q) begin
          den_q <= ProdW'(pb_q - pa_q) * ProdW'(y_q);
          num_q <= x_ext_w - ProdW'(pa_q) * ProdW'(y_q);
        end else begin
          den_q <= ProdW'(1);
          num_q <= '0;
        end
      end
      S_STORE: bytes_q[chan_q] <= byte_w;
      default: ;
    endcase
    if (out_load_w) begin
      out_q.entry_out  <= idx_q;
      out_q.red_byte   <= bytes_q[0];
      out_q.green_byte <= bytes_q[1];
      out_q.blue_byte  <= bytes_q[2];
      out_q.alpha_byte <= bytes_q[3];
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule
